FILE: hw/rtl/nnp_pkg.sv
// shared types and constants for the nearest node proximity unit
package nnp_pkg;

  localparam int NODE_W        = 32;
  localparam int THR_W         = 31;
  localparam int CNT_CFG_W     = 5;
  localparam int SLOT_W        = 4;
  localparam int FRAC_W        = 17;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 31;
  localparam int DIV_STEPS     = 17;
  localparam int MAX_NODES_DEF = 16;

  localparam logic [FRAC_W-1:0] ONE_Q16   = 17'd65536;
  localparam logic [THR_W-1:0]  THR_RESET = 31'd65536;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THR_LEFT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THR_RIGHT  = 2'd2;

  // search token handed from cell to cell
  typedef struct packed {
    logic [NODE_W-1:0] p;
    logic [NODE_W-1:0] best;
    logic [NODE_W-1:0] best_d;
    logic              found;
    logic [NODE_W-1:0] first;
    logic [NODE_W-1:0] last;
  } chain_tok_t;

endpackage

FILE: hw/rtl/nearest_node_proximity_unit.sv
// top level: node table as a chain of cells, query sequencer and result register
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+------------------------------
//  input   | in_kind, in_node_index, in_value        | start & !busy
//  result  | out_near, out_nearing                   | out_strobe, one cycle, no stall
//  config  | cfg_index, cfg_wdata                    | cfg_we, taken at once
//
// a node write leaves busy low
// a query walks the token down the MAX_NODES cells, one cell a cycle, then judges the
// result and, where a fraction is needed, runs the 17-step serial divider;
// answers that need no division skip the divider
// synchronous reset clears node_count and sets both thresholds to 1.0; table is not cleared
// the result is shown for one cycle; the receiver cannot hold it off
module nearest_node_proximity_unit #(
  parameter int MAX_NODES = nnp_pkg::MAX_NODES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic                            in_kind,
  input  logic [nnp_pkg::SLOT_W-1:0]      in_node_index,
  input  logic signed [nnp_pkg::NODE_W-1:0] in_value,
  output logic                            out_strobe,
  output logic                            out_near,
  output logic [nnp_pkg::FRAC_W-1:0]      out_nearing,
  input  logic                            cfg_we,
  input  logic [nnp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [nnp_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import nnp_pkg::*;

  localparam int CNT_W = $clog2(MAX_NODES + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_JUDGE = 2'd2;
  localparam logic [1:0] S_DIV   = 2'd3;

  logic [1:0]           state_r, state_nxt;
  logic [CNT_W-1:0]     scan_cnt_r, scan_cnt_nxt;
  logic [NODE_W-1:0]    p_r, p_nxt;
  logic                 out_strobe_r, out_strobe_nxt;
  logic                 out_near_r, out_near_nxt;
  logic [FRAC_W-1:0]    out_nearing_r, out_nearing_nxt;
  logic [CNT_CFG_W-1:0] node_count_r;
  logic [THR_W-1:0]     thr_left_r;
  logic [THR_W-1:0]     thr_right_r;

  logic                 accept;
  logic                 node_we;
  logic [CNT_W-1:0]     n_eff;
  chain_tok_t           chain [0:MAX_NODES];
  chain_tok_t           tok;
  logic                 p_ge_best;
  logic [THR_W-1:0]     thr_sel;
  logic                 far;
  logic                 many;
  logic                 div_start;
  logic [THR_W-1:0]     div_rem;
  logic                 div_done;
  logic [FRAC_W-1:0]    div_quo;

  assign busy    = (state_r != S_IDLE);
  assign accept  = start && !busy;
  assign node_we = accept && in_kind;
  assign n_eff   = (32'(node_count_r) > MAX_NODES) ? CNT_W'(MAX_NODES) : CNT_W'(node_count_r);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= '0;
      thr_left_r   <= THR_RESET;
      thr_right_r  <= THR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NODE_COUNT: node_count_r <= cfg_wdata[CNT_CFG_W-1:0];
        CFG_THR_LEFT:   thr_left_r   <= cfg_wdata[THR_W-1:0];
        CFG_THR_RIGHT:  thr_right_r  <= cfg_wdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // fresh token enters the first cell every cycle
  always_comb begin
    chain[0]        = '0;
    chain[0].p      = p_r;
    chain[0].found  = 1'b0;
  end

  for (genvar i = 0; i < MAX_NODES; i++) begin : g_cell
    nnp_cell #(
      .MAX_NODES (MAX_NODES),
      .IDX       (i)
    ) u_cell (
      .clk       (clk),
      .node_we   (node_we),
      .node_slot (in_node_index),
      .node_val  (in_value),
      .n_eff     (n_eff),
      .tok_in    (chain[i]),
      .tok_out   (chain[i+1])
    );
  end

  nnp_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .rem_in (div_rem),
    .den_in (thr_sel),
    .done   (div_done),
    .quo    (div_quo)
  );

  always_comb begin
    tok       = chain[MAX_NODES];
    p_ge_best = $signed(p_r) >= $signed(tok.best);
    thr_sel   = p_ge_best ? thr_right_r : thr_left_r;
    far       = tok.best_d >= {1'b0, thr_sel};
    many      = n_eff > CNT_W'(1);
    div_rem   = THR_W'({1'b0, thr_sel} - tok.best_d);
  end

  always_comb begin
    state_nxt       = state_r;
    scan_cnt_nxt    = scan_cnt_r;
    p_nxt           = p_r;
    out_strobe_nxt  = 1'b0;
    out_near_nxt    = out_near_r;
    out_nearing_nxt = out_nearing_r;
    div_start       = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept && !in_kind) begin
          p_nxt        = in_value;
          scan_cnt_nxt = '0;
          state_nxt    = S_SCAN;
        end
      end
      S_SCAN: begin
        scan_cnt_nxt = scan_cnt_r + CNT_W'(1);
        if (scan_cnt_r == CNT_W'(MAX_NODES - 1)) begin
          state_nxt = S_JUDGE;
        end
      end
      S_JUDGE: begin
        state_nxt = S_IDLE;
        if (n_eff == '0) begin
          out_strobe_nxt  = 1'b1;
          out_near_nxt    = 1'b0;
          out_nearing_nxt = '0;
        end else if (many && ($signed(p_r) > $signed(tok.last))) begin
          out_strobe_nxt  = 1'b1;
          out_near_nxt    = 1'b1;
          out_nearing_nxt = ONE_Q16;
        end else if ((many && ($signed(p_r) < $signed(tok.first))) || far) begin
          out_strobe_nxt  = 1'b1;
          out_near_nxt    = 1'b0;
          out_nearing_nxt = '0;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          out_strobe_nxt  = 1'b1;
          out_near_nxt    = 1'b1;
          out_nearing_nxt = div_quo;
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      scan_cnt_r   <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      scan_cnt_r   <= scan_cnt_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
    p_r           <= p_nxt;
    out_near_r    <= out_near_nxt;
    out_nearing_r <= out_nearing_nxt;
  end

  assign out_strobe  = out_strobe_r;
  assign out_near    = out_near_r;
  assign out_nearing = out_nearing_r;

  // a node write transaction never yields a result
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_kind) |=> !out_strobe)
    else $error("result strobe after a node write");

  // a query transaction always occupies the unit on the next cycle
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_kind) |=> busy)
    else $error("query accepted but unit not busy");

  // a not-near answer carries a zero fraction, and the fraction never exceeds 1.0
  a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ((out_nearing <= ONE_Q16) && (out_near || (out_nearing == '0))))
    else $error("nearing fraction out of range");

  // the divider only finishes while the sequencer waits on it
  a_div_owned: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider finished outside its wait state");

endmodule

FILE: hw/rtl/nnp_cell.sv
// one node slot of the search chain: holds a node and refines the passing token
module nnp_cell #(
  parameter int MAX_NODES = nnp_pkg::MAX_NODES_DEF,
  parameter int IDX       = 0
) (
  input  logic                               clk,
  input  logic                               node_we,
  input  logic [nnp_pkg::SLOT_W-1:0]         node_slot,
  input  logic [nnp_pkg::NODE_W-1:0]         node_val,
  input  logic [$clog2(MAX_NODES+1)-1:0]     n_eff,
  input  nnp_pkg::chain_tok_t                tok_in,
  output nnp_pkg::chain_tok_t                tok_out
);
  import nnp_pkg::*;

  logic [NODE_W-1:0] node_r;
  chain_tok_t        tok_r;
  chain_tok_t        tok_nxt;
  logic signed [NODE_W:0] diff;
  logic [NODE_W-1:0] gap;
  logic              active;
  logic              take;

  always_ff @(posedge clk) begin
    if (node_we && (32'(node_slot) == IDX)) begin
      node_r <= node_val;
    end
  end

  always_comb begin
    diff   = $signed({tok_in.p[NODE_W-1], tok_in.p}) - $signed({node_r[NODE_W-1], node_r});
    gap    = diff[NODE_W] ? NODE_W'(-diff) : NODE_W'(diff);
    active = IDX < 32'(n_eff);
    // strict compare keeps the first node at the minimum distance
    take   = active && (!tok_in.found || (gap < tok_in.best_d));
    tok_nxt = tok_in;
    if (take) begin
      tok_nxt.best   = node_r;
      tok_nxt.best_d = gap;
      tok_nxt.found  = 1'b1;
    end
    if (IDX == 0) begin
      tok_nxt.first = node_r;
    end
    if (active && ((IDX + 1) == 32'(n_eff))) begin
      tok_nxt.last = node_r;
    end
  end

  always_ff @(posedge clk) begin
    tok_r <= tok_nxt;
  end

  assign tok_out = tok_r;

endmodule

FILE: hw/rtl/nnp_div.sv
// serial restoring divider for the nearing fraction, one quotient bit per cycle
module nnp_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [nnp_pkg::THR_W-1:0]   rem_in,
  input  logic [nnp_pkg::THR_W-1:0]   den_in,
  output logic                        done,
  output logic [nnp_pkg::FRAC_W-1:0]  quo
);
  import nnp_pkg::*;

  localparam int STEP_W = $clog2(DIV_STEPS);

  logic              run_r, run_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [THR_W-1:0]  rem_r, rem_nxt;
  logic [THR_W-1:0]  den_r, den_nxt;
  logic [FRAC_W-1:0] quo_r, quo_nxt;
  logic [THR_W:0]    trial;
  logic              ge;

  always_comb begin
    // the first step yields the integer bit, so no shift there
    trial    = (step_r == '0) ? {1'b0, rem_r} : {rem_r, 1'b0};
    ge       = trial >= {1'b0, den_r};
    run_nxt  = run_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    if (start) begin
      run_nxt  = 1'b1;
      step_nxt = '0;
      rem_nxt  = rem_in;
      den_nxt  = den_in;
      quo_nxt  = '0;
    end else if (run_r) begin
      rem_nxt  = ge ? THR_W'(trial - {1'b0, den_r}) : THR_W'(trial);
      quo_nxt  = {quo_r[FRAC_W-2:0], ge};
      step_nxt = step_r + STEP_W'(1);
      if (step_r == STEP_W'(DIV_STEPS - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule
